// ===== hdl/vdi_pkg.sv =====
// shared constants for the vertex dedup indexer
`default_nettype none

package vdi_pkg;

	// table depth and derived widths
	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// vertex layout: eight signed q16.16 components
	localparam int NCOMP  = 8;
	localparam int COMP_W = 32;
	localparam int DIFF_W = COMP_W + 1;
	localparam int DATA_W = NCOMP * COMP_W;

	// tolerance register
	localparam int             TOL_W     = 17;
	localparam logic [TOL_W-1:0] TOL_RESET = 17'd655;

	// result payload
	localparam int VIDX_W     = 10;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;

endpackage

`default_nettype wire

// ===== hdl/vertex_dedup_indexer_core.sv =====
// vertex dedup indexer: welds near-identical vertices into a unique table
//
// usage
//   s_axis carries one vertex per item: tdata holds pos xyz, norm xyz, tex uv
//   (eight signed q16.16 words, pos_x lowest), tuser carries start_mesh which
//   empties the unique table before the vertex is handled.
//   m_axis returns one item per vertex: tdata holds vertex_index, tuser holds
//   is_new (bit 0) and overflow (bit 1).
//   cfg_we/cfg_wdata write match_tolerance; write it only while the block is idle.
// timing
//   one 256-bit wide synchronous ram, one entry read per cycle. a miss reads all
//   N stored vertices (up to 1024), then passes the difference register, pipeline
//   drain, done state and output register; a hit on entry i ends the scan once
//   entry i reaches the compare, and an empty table goes straight to the done
//   state. a new item is taken only after the result has left the done state.
// reset and stalls
//   reset empties the table (count to zero) and loads tolerance 655; ram
//   contents are not cleared, only entries below the count are ever read.
//   a finished result waits in the output register; if the receiver stalls the
//   next result holds in the done state and no further item is taken.
`default_nettype none

module vertex_dedup_indexer_core
	import vdi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [TOL_W-1:0]      cfg_wdata,      // match_tolerance
	// vertex input
	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [DATA_W-1:0]     s_axis_tdata,   // pos_x, pos_y, pos_z, norm_x,
	                                                   // norm_y, norm_z, tex_u, tex_v
	input  wire logic                  s_axis_tuser,   // start_mesh
	// index output
	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [OUT_DATA_W-1:0] m_axis_tdata,   // vertex_index, zero pad
	output      logic [OUT_USER_W-1:0] m_axis_tuser    // is_new, overflow
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [TOL_W-1:0]  tol_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [DATA_W-1:0] vtx_q;

	// scan pipeline
	logic              v_s1_q, v_s2_q;
	logic [IDX_W-1:0]  idx_s1, idx_s2;
	logic [DATA_W-1:0] rd_data_s1;
	logic [DIFF_W-1:0] diff_s2 [NCOMP];

	// pending result
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_new_q, res_ovf_q;

	// output register
	logic              out_valid_q;
	logic [VIDX_W-1:0] out_idx_q;
	logic              out_new_q, out_ovf_q;

	// the table
	logic [DATA_W-1:0] mem [MAX_VERTICES];

	logic              accept, rd_more, rd_en, hit, finish_hit, finish_miss;
	logic              ld_out, mem_we, table_full;
	logic [NCOMP-1:0]  close;
	logic [DIFF_W-1:0] tol_ext, neg_tol;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// read one stored entry a cycle until the count is reached
	assign rd_more = (rd_idx_q < cnt_q);
	assign rd_en   = (state_q == ST_SCAN) && rd_more;

	// |a - b| < tol  <=>  -tol < (a - b) < tol, differences exact at 33 bits
	assign tol_ext = DIFF_W'(tol_q);
	assign neg_tol = -tol_ext;

	always_comb begin
		for (int c = 0; c < NCOMP; c++) begin
			close[c] = ($signed(diff_s2[c]) < $signed(tol_ext)) &&
			           ($signed(diff_s2[c]) > $signed(neg_tol));
		end
	end

	assign hit         = v_s2_q && (&close);
	assign finish_hit  = (state_q == ST_SCAN) && hit;
	// no read left and pipeline drained without a hit
	assign finish_miss = (state_q == ST_SCAN) && !rd_more && !v_s1_q && !v_s2_q;
	assign table_full  = (cnt_q == CNT_W'(MAX_VERTICES));

	// result leaves when the output register is free; append happens here too,
	// after all reads of this item and before the next item can start a scan
	assign ld_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign mem_we = ld_out && res_new_q;

	// ram: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[IDX_W-1:0]] <= vtx_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			vtx_q <= s_axis_tdata;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		for (int c = 0; c < NCOMP; c++) begin
			diff_s2[c] <= {vtx_q[c*COMP_W + COMP_W - 1], vtx_q[c*COMP_W +: COMP_W]} -
			              {rd_data_s1[c*COMP_W + COMP_W - 1], rd_data_s1[c*COMP_W +: COMP_W]};
		end
		if (finish_hit) begin
			res_idx_q <= idx_s2;
		end else if (finish_miss) begin
			res_idx_q <= table_full ? '0 : cnt_q[IDX_W-1:0];
		end
		if (ld_out) begin
			out_idx_q <= VIDX_W'(res_idx_q);
			out_new_q <= res_new_q;
			out_ovf_q <= res_ovf_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tol_q       <= TOL_RESET;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			res_new_q   <= 1'b0;
			res_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end

			// a hit flushes whatever read is still in flight
			v_s1_q <= rd_en && !finish_hit;
			v_s2_q <= v_s1_q && !finish_hit;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end

			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						if (s_axis_tuser) begin
							cnt_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (finish_hit) begin
						res_new_q <= 1'b0;
						res_ovf_q <= 1'b0;
						state_q   <= ST_DONE;
					end else if (finish_miss) begin
						res_new_q <= !table_full;
						res_ovf_q <= table_full;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ld_out) begin
						if (res_new_q) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - VIDX_W){1'b0}}, out_idx_q};
	assign m_axis_tuser  = {out_ovf_q, out_new_q};

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES))
		else $error("unique count beyond table depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !table_full)
		else $error("append into a full table");

	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("append did not advance the count");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result posted outside the done state");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_new_q && out_ovf_q))
		else $error("result both new and overflow");

endmodule

`default_nettype wire
